### rtl/dlpc_pkg.sv
// Shared widths and codes for the directory listing presence cache.
// No dependencies; imported by the top level.
package dlpc_pkg;

    localparam int KIND_W   = 3;
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ANS_W    = 3;
    localparam int THR_W    = 8;

    localparam logic [THR_W-1:0] THR_RESET = 8'd4;
    localparam logic [THR_W-1:0] AGR_MAX   = 8'd255;

    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OBSERVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FORGET  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BEGIN   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NAME    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_LISTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;

    localparam logic [ANS_W-1:0] ANS_UNKNOWN = 3'd0;
    localparam logic [ANS_W-1:0] ANS_PRESENT = 3'd1;
    localparam logic [ANS_W-1:0] ANS_ABSENT  = 3'd2;
    localparam logic [ANS_W-1:0] ANS_NEEDS   = 3'd3;
    localparam logic [ANS_W-1:0] ANS_ACK     = 3'd4;

endpackage

### rtl/dlpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dlpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/dir_listing_presence_cache.sv
// Directory listing presence cache: top level with slot table and sequencer.
// Depends on dlpc_pkg and dlpc_ram (name hash store).
//
// One transaction is taken at a time; the next is accepted only after the last
// one's result has been registered. Items that probe the name store (lookup,
// observe, list name) pass through S_RD and S_CHK for each probe step, since
// each step waits on the store's registered read.
// Begin, forget and a failed list end sweep the slot's NAMES_PER_DIR entries,
// one per cycle, when the slot holds any names. After reset the whole store
// (2**ceil(log2(DIR_SLOTS)) * NAMES_PER_DIR entries, 16384 by default) is
// zeroed one entry per cycle before the first transaction is taken;
// configuration writes are taken throughout. NAMES_PER_DIR must be a power
// of two.
module dir_listing_presence_cache #(
    parameter int DIR_SLOTS     = 16,
    parameter int NAMES_PER_DIR = 1024,
    localparam int SW      = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1,
    localparam int CW      = $clog2(NAMES_PER_DIR + 1),
    localparam int OUT_W   = dlpc_pkg::ANS_W + SW + CW,
    localparam int OUT_BYT = (OUT_W + 7) / 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [dlpc_pkg::THR_W-1:0]  cfg_wr_data,  // verify_threshold
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [71:0]                 s_tdata,  // dir_key, file_hash, existed, list_status
    input  logic [dlpc_pkg::KIND_W-1:0] s_tuser,  // kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_BYT*8-1:0]        m_tdata   // answer, slot_index, name_total
);
    import dlpc_pkg::*;

    localparam int NW = $clog2(NAMES_PER_DIR);
    localparam int AW = SW + NW;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_DEC, S_RD, S_CHK, S_SWEEP, S_DONE
    } state_t;

    state_t                state_reg;
    logic [THR_W-1:0]      thr_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [HASH_W-1:0]     hash_reg;
    logic                  existed_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [KEY_W-1:0]      keys_reg     [DIR_SLOTS];
    logic [CW-1:0]         counts_reg   [DIR_SLOTS];
    logic                  complete_reg [DIR_SLOTS];
    logic                  retired_reg  [DIR_SLOTS];
    logic [THR_W-1:0]      agr_reg      [DIR_SLOTS];
    logic [SW-1:0]         victim_reg;
    logic [SW-1:0]         ls_reg;
    logic                  open_reg;

    logic [SW-1:0]         slot_reg;
    logic [ANS_W-1:0]      ans_reg;
    logic                  zero_tot_reg;
    logic [NW-1:0]         probe_reg;
    logic [AW-1:0]         clr_reg;

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;

    logic                  found;
    logic [SW-1:0]         fidx;
    logic [NW-1:0]         pos;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [HASH_W-1:0]     ram_wr_data;
    logic                  ram_rd_en;
    logic [HASH_W-1:0]     ram_rd_data;
    logic                  hit;
    logic                  empty;
    logic                  last_probe;
    logic [SW-1:0]         victim_inc;
    logic [SW-1:0]         begin_slot;

    // Keys are unique, so at most one slot matches.
    always_comb
    begin
        found = 1'b0;
        fidx  = '0;
        for (int i = 0; i < DIR_SLOTS; i++)
        begin
            if (key_reg != '0 && keys_reg[i] == key_reg)
            begin
                found = 1'b1;
                fidx  = SW'(i);
            end
        end
    end

    assign pos        = hash_reg[NW-1:0] + probe_reg;
    assign hit        = (ram_rd_data == hash_reg);
    assign empty      = (ram_rd_data == '0);
    assign last_probe = &probe_reg;
    assign victim_inc = (victim_reg == SW'(DIR_SLOTS - 1)) ? '0 : victim_reg + 1'b1;
    assign begin_slot = found ? fidx : victim_reg;

    assign ram_rd_en   = (state_reg == S_RD);
    assign ram_wr_en   = (state_reg == S_INIT) || (state_reg == S_SWEEP) ||
                         (state_reg == S_CHK && kind_reg == KIND_NAME && empty);
    assign ram_wr_data = (state_reg == S_CHK) ? hash_reg : '0;

    always_comb
    begin
        case (state_reg)
            S_INIT:  ram_wr_addr = clr_reg;
            S_SWEEP: ram_wr_addr = {slot_reg, clr_reg[NW-1:0]};
            default: ram_wr_addr = {slot_reg, pos};
        endcase
    end

    dlpc_ram #(
        .WIDTH (HASH_W),
        .DEPTH (1 << AW)
    ) u_names (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr ({slot_reg, pos}),
        .rd_data (ram_rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_BYT*8 - OUT_W){1'b0}}, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            thr_reg       <= THR_RESET;
            kind_reg      <= '0;
            key_reg       <= '0;
            hash_reg      <= '0;
            existed_reg   <= 1'b0;
            status_reg    <= '0;
            for (int i = 0; i < DIR_SLOTS; i++)
            begin
                keys_reg[i]     <= '0;
                counts_reg[i]   <= '0;
                complete_reg[i] <= 1'b0;
                retired_reg[i]  <= 1'b0;
                agr_reg[i]      <= '0;
            end
            victim_reg    <= '0;
            ls_reg        <= '0;
            open_reg      <= 1'b0;
            slot_reg      <= '0;
            ans_reg       <= ANS_UNKNOWN;
            zero_tot_reg  <= 1'b0;
            probe_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_INIT:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg    <= s_tuser;
                        key_reg     <= s_tdata[31:0];
                        hash_reg    <= (s_tdata[63:32] == '0) ? HASH_W'(1) : s_tdata[63:32];
                        existed_reg <= s_tdata[64];
                        status_reg  <= s_tdata[66:65];
                        state_reg   <= S_DEC;
                    end
                end

                S_DEC:
                begin
                    zero_tot_reg <= 1'b0;
                    probe_reg    <= '0;
                    clr_reg      <= '0;
                    ans_reg      <= ANS_ACK;
                    slot_reg     <= '0;
                    state_reg    <= S_DONE;
                    case (kind_reg)
                        KIND_LOOKUP:
                        begin
                            if (key_reg == '0)
                            begin
                                ans_reg      <= ANS_UNKNOWN;
                                zero_tot_reg <= 1'b1;
                            end
                            else if (!found)
                            begin
                                ans_reg      <= ANS_NEEDS;
                                slot_reg     <= victim_reg;
                                zero_tot_reg <= 1'b1;
                            end
                            else
                            begin
                                slot_reg <= fidx;
                                ans_reg  <= ANS_UNKNOWN;
                                if (!(open_reg && ls_reg == fidx) && complete_reg[fidx])
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                        end

                        KIND_OBSERVE:
                        begin
                            if (!found)
                            begin
                                zero_tot_reg <= 1'b1;
                            end
                            else
                            begin
                                slot_reg <= fidx;
                                if (complete_reg[fidx])
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                        end

                        KIND_FORGET:
                        begin
                            if (!found)
                            begin
                                zero_tot_reg <= 1'b1;
                            end
                            else
                            begin
                                slot_reg           <= fidx;
                                keys_reg[fidx]     <= '0;
                                complete_reg[fidx] <= 1'b0;
                                retired_reg[fidx]  <= 1'b0;
                                agr_reg[fidx]      <= '0;
                                counts_reg[fidx]   <= '0;
                                if (open_reg && ls_reg == fidx)
                                begin
                                    open_reg <= 1'b0;
                                end
                                if (counts_reg[fidx] != '0)
                                begin
                                    state_reg <= S_SWEEP;
                                end
                            end
                        end

                        KIND_BEGIN:
                        begin
                            if (key_reg == '0)
                            begin
                                zero_tot_reg <= 1'b1;
                            end
                            else
                            begin
                                // old open listing is left incomplete unless it
                                // is the slot being relisted
                                if (open_reg && ls_reg != begin_slot)
                                begin
                                    complete_reg[ls_reg] <= 1'b0;
                                end
                                if (!found)
                                begin
                                    victim_reg <= victim_inc;
                                end
                                slot_reg                 <= begin_slot;
                                keys_reg[begin_slot]     <= key_reg;
                                complete_reg[begin_slot] <= 1'b1;
                                retired_reg[begin_slot]  <= 1'b0;
                                agr_reg[begin_slot]      <= '0;
                                counts_reg[begin_slot]   <= '0;
                                ls_reg                   <= begin_slot;
                                open_reg                 <= 1'b1;
                                if (counts_reg[begin_slot] != '0)
                                begin
                                    state_reg <= S_SWEEP;
                                end
                            end
                        end

                        KIND_NAME:
                        begin
                            slot_reg <= ls_reg;
                            if (open_reg)
                            begin
                                state_reg <= S_RD;
                            end
                        end

                        KIND_END:
                        begin
                            slot_reg <= ls_reg;
                            if (open_reg)
                            begin
                                open_reg <= 1'b0;
                                if (status_reg != STATUS_LISTED)
                                begin
                                    complete_reg[ls_reg] <= (status_reg == STATUS_MISSING);
                                    counts_reg[ls_reg]   <= '0;
                                    if (counts_reg[ls_reg] != '0)
                                    begin
                                        state_reg <= S_SWEEP;
                                    end
                                end
                            end
                        end

                        default:
                        begin
                            ans_reg      <= ANS_UNKNOWN;
                            zero_tot_reg <= 1'b1;
                        end
                    endcase
                end

                S_RD:
                begin
                    state_reg <= S_CHK;
                end

                S_CHK:
                begin
                    if (kind_reg == KIND_NAME)
                    begin
                        if (empty)
                        begin
                            counts_reg[slot_reg] <= counts_reg[slot_reg] + 1'b1;
                            state_reg            <= S_DONE;
                        end
                        else if (hit)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (last_probe)
                        begin
                            complete_reg[slot_reg] <= 1'b0;
                            state_reg              <= S_DONE;
                        end
                        else
                        begin
                            probe_reg <= probe_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                    else if (empty || hit || last_probe)
                    begin
                        state_reg <= S_DONE;
                        if (kind_reg == KIND_LOOKUP)
                        begin
                            if (hit)
                            begin
                                ans_reg <= ANS_PRESENT;
                            end
                            else if (!retired_reg[slot_reg] && agr_reg[slot_reg] >= thr_reg)
                            begin
                                ans_reg <= ANS_ABSENT;
                            end
                        end
                        else if (!hit)
                        begin
                            if (existed_reg)
                            begin
                                retired_reg[slot_reg] <= 1'b1;
                            end
                            else if (agr_reg[slot_reg] != AGR_MAX)
                            begin
                                agr_reg[slot_reg] <= agr_reg[slot_reg] + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        probe_reg <= probe_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end

                S_SWEEP:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg[NW-1:0])
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {zero_tot_reg ? CW'(0) : counts_reg[slot_reg],
                                          slot_reg, ans_reg};
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // An open listing always belongs to a held directory.
    assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> keys_reg[ls_reg] != '0)
        else $error("open listing on an empty slot");

    // The name store is only written while a transaction or the init pass runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> state_reg != S_IDLE && state_reg != S_DONE)
        else $error("name store written while idle");

    // The selected slot never counts more names than its table holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        counts_reg[slot_reg] <= CW'(NAMES_PER_DIR))
        else $error("slot name count overflow");

    // A result never carries an undefined answer code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg[ANS_W-1:0] <= ANS_ACK)
        else $error("bad answer code");

endmodule
